@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Short wrappers for the concurrent checks that the RTL carries.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When ante holds at a clock edge, cons holds at the same edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// When ante holds at a clock edge, cons holds at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ rtl/tsp_pkg.sv @@
// ---------------------------------------------------------------------------
// Transaction stream parser package
// Field codes, parse state and per-byte result types shared by the RTL.
// ---------------------------------------------------------------------------
package tsp_pkg;

   localparam int unsigned HASH_BYTES   = 32;
   localparam int unsigned MAX_ENTRIES  = 65535;
   localparam int unsigned WORD_BYTES   = 4;
   localparam int unsigned AMOUNT_BYTES = 8;

   localparam logic [7:0] VARINT_PREFIX_2 = 8'hFD;
   localparam logic [7:0] VARINT_PREFIX_4 = 8'hFE;

   localparam logic [31:0] MAX_SCRIPT_LEN = 32'hFFFF_FFFF;

   // Field codes; the parse phase uses the same codes as the reported kind.
   typedef enum logic [3:0] {
      KIND_VERSION   = 4'd0,
      KIND_INCOUNT   = 4'd1,
      KIND_PREVHASH  = 4'd2,
      KIND_PREVIDX   = 4'd3,
      KIND_INSCRLEN  = 4'd4,
      KIND_INSCRIPT  = 4'd5,
      KIND_SEQUENCE  = 4'd6,
      KIND_OUTCOUNT  = 4'd7,
      KIND_AMOUNT    = 4'd8,
      KIND_OUTSCRLEN = 4'd9,
      KIND_OUTSCRIPT = 4'd10,
      KIND_LOCKTIME  = 4'd11,
      KIND_STRAY     = 4'd12
   } field_kind_type;

   typedef struct packed {
      field_kind_type phase;
      logic [5:0]     field_position;
      logic [63:0]    value_accumulator;
      logic [3:0]     varint_bytes_left;
      logic [15:0]    entries_left;
      logic [15:0]    entry_counter;
      logic [31:0]    script_bytes_left;
      logic [31:0]    script_offset;
      logic [63:0]    amount_sum;
      logic           finished;
   } parse_state_type;

   typedef struct packed {
      field_kind_type field_kind;
      logic [15:0]    entry_number;
      logic [31:0]    byte_offset;
      logic [63:0]    field_value;
      logic           value_valid;
      logic           field_last;
      logic           transaction_done;
      logic [63:0]    output_total;
      logic           parse_error;
   } step_result_type;

   localparam parse_state_type STATE_RESET = '{
      phase:             KIND_VERSION,
      field_position:    6'd0,
      value_accumulator: 64'd0,
      varint_bytes_left: 4'd0,
      entries_left:      16'd0,
      entry_counter:     16'd0,
      script_bytes_left: 32'd0,
      script_offset:     32'd0,
      amount_sum:        64'd0,
      finished:          1'b0
   };

endpackage

@@ rtl/tsp_stream_if.sv @@
// ---------------------------------------------------------------------------
// Transaction stream parser channels
// Valid/ready channels for raw bytes in and tagged byte results out.
// ---------------------------------------------------------------------------
interface tsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       first_byte;

   modport source (output valid, output byte_value, output first_byte, input ready);
   modport sink   (input valid, input byte_value, input first_byte, output ready);
endinterface

interface tsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  field_kind;
   logic [15:0] entry_number;
   logic [31:0] byte_offset;
   logic [63:0] field_value;
   logic        value_valid;
   logic        field_last;
   logic        transaction_done;
   logic [63:0] output_total;
   logic        parse_error;

   modport source (output valid, output field_kind, output entry_number,
                   output byte_offset, output field_value, output value_valid,
                   output field_last, output transaction_done,
                   output output_total, output parse_error, input ready);
   modport sink   (input valid, input field_kind, input entry_number,
                   input byte_offset, input field_value, input value_valid,
                   input field_last, input transaction_done,
                   input output_total, input parse_error, output ready);
endinterface

@@ rtl/tsp_field_step.sv @@
// ---------------------------------------------------------------------------
// Transaction stream parser field step
// Next parse state and tagged result for one raw byte.
// ---------------------------------------------------------------------------
module tsp_field_step (
   input  tsp_pkg::parse_state_type state_cur,
   input  logic [7:0]               byte_value,
   input  logic                     first_byte,
   output tsp_pkg::parse_state_type state_nxt,
   output tsp_pkg::step_result_type result
);
   import tsp_pkg::*;

   parse_state_type s;
   parse_state_type n;
   step_result_type r;

   logic [5:0]  fp;
   logic [5:0]  fp_m1;
   logic [63:0] fixed_acc;
   logic [63:0] var_acc;
   logic        word_done;
   logic        amount_done;
   logic        var_done;
   logic [63:0] var_value;
   logic [5:0]  var_fp_next;
   logic [63:0] var_acc_next;
   logic [3:0]  var_left_next;
   logic [3:0]  var_left_dec;
   logic        cnt_err;
   logic [15:0] cnt_entries;
   logic        len_err;
   logic [31:0] len_value;
   logic [15:0] entries_dec;

   // Shared datapath pieces for fixed fields, varints, counts and lengths.
   always_comb begin
      s           = first_byte ? STATE_RESET : state_cur;
      fp          = s.field_position;
      fp_m1       = fp - 6'd1;
      fixed_acc   = s.value_accumulator | ({56'd0, byte_value} << {fp[2:0], 3'b000});
      var_acc     = s.value_accumulator | ({56'd0, byte_value} << {fp_m1[2:0], 3'b000});
      word_done   = fp >= 6'(WORD_BYTES - 1);
      amount_done = fp >= 6'(AMOUNT_BYTES - 1);
      var_left_dec = s.varint_bytes_left - 4'd1;

      if (fp == 6'd0) begin
         var_fp_next  = 6'd1;
         var_acc_next = 64'd0;
         if (byte_value < VARINT_PREFIX_2) begin
            var_done      = 1'b1;
            var_value     = {56'd0, byte_value};
            var_left_next = 4'd0;
         end else begin
            var_done  = 1'b0;
            var_value = 64'd0;
            case (byte_value)
               VARINT_PREFIX_2: var_left_next = 4'd2;
               VARINT_PREFIX_4: var_left_next = 4'd4;
               default:         var_left_next = 4'd8;
            endcase
         end
      end else begin
         var_fp_next   = fp + 6'd1;
         var_acc_next  = var_acc;
         var_left_next = var_left_dec;
         var_done      = var_left_dec == 4'd0;
         var_value     = var_acc;
      end

      cnt_err     = var_value > 64'(MAX_ENTRIES);
      cnt_entries = cnt_err ? 16'(MAX_ENTRIES) : var_value[15:0];
      len_err     = |var_value[63:32];
      len_value   = len_err ? MAX_SCRIPT_LEN : var_value[31:0];
      entries_dec = s.entries_left - 16'd1;
   end

   // Phase sequencing. Leaving a field clears position, accumulator and
   // varint count, which is written after the per-byte updates.
   always_comb begin
      n = s;
      r = '{field_kind: KIND_STRAY, default: '0};

      if (s.finished) begin
         r.parse_error = 1'b1;
      end else begin
         r.field_kind = s.phase;
         case (s.phase)
            KIND_VERSION, KIND_PREVIDX, KIND_SEQUENCE, KIND_LOCKTIME: begin
               if (s.phase != KIND_VERSION && s.phase != KIND_LOCKTIME) begin
                  r.entry_number = s.entry_counter;
               end
               r.byte_offset       = {26'd0, fp};
               n.field_position    = fp + 6'd1;
               n.value_accumulator = fixed_acc;
               if (word_done) begin
                  r.field_value = fixed_acc;
                  r.value_valid = 1'b1;
                  r.field_last  = 1'b1;
                  case (s.phase)
                     KIND_VERSION: begin
                        n.phase             = KIND_INCOUNT;
                        n.field_position    = 6'd0;
                        n.value_accumulator = 64'd0;
                        n.varint_bytes_left = 4'd0;
                     end
                     KIND_PREVIDX: begin
                        n.phase             = KIND_INSCRLEN;
                        n.field_position    = 6'd0;
                        n.value_accumulator = 64'd0;
                        n.varint_bytes_left = 4'd0;
                     end
                     KIND_SEQUENCE: begin
                        n.entries_left      = entries_dec;
                        n.entry_counter     = s.entry_counter + 16'd1;
                        n.phase             = (entries_dec != 16'd0) ? KIND_PREVHASH
                                                                    : KIND_OUTCOUNT;
                        n.field_position    = 6'd0;
                        n.value_accumulator = 64'd0;
                        n.varint_bytes_left = 4'd0;
                     end
                     default: begin
                        r.transaction_done = 1'b1;
                        r.output_total     = s.amount_sum;
                        n.finished         = 1'b1;
                     end
                  endcase
               end
            end
            KIND_AMOUNT: begin
               r.entry_number      = s.entry_counter;
               r.byte_offset       = {26'd0, fp};
               n.field_position    = fp + 6'd1;
               n.value_accumulator = fixed_acc;
               if (amount_done) begin
                  r.field_value       = fixed_acc;
                  r.value_valid       = 1'b1;
                  r.field_last        = 1'b1;
                  n.amount_sum        = s.amount_sum + fixed_acc;
                  n.phase             = KIND_OUTSCRLEN;
                  n.field_position    = 6'd0;
                  n.value_accumulator = 64'd0;
                  n.varint_bytes_left = 4'd0;
               end
            end
            KIND_INCOUNT, KIND_OUTCOUNT, KIND_INSCRLEN, KIND_OUTSCRLEN: begin
               if (s.phase == KIND_INSCRLEN || s.phase == KIND_OUTSCRLEN) begin
                  r.entry_number = s.entry_counter;
               end
               r.byte_offset       = {26'd0, fp};
               n.field_position    = var_fp_next;
               n.value_accumulator = var_acc_next;
               n.varint_bytes_left = var_left_next;
               if (var_done) begin
                  r.field_value       = var_value;
                  r.value_valid       = 1'b1;
                  r.field_last        = 1'b1;
                  n.field_position    = 6'd0;
                  n.value_accumulator = 64'd0;
                  n.varint_bytes_left = 4'd0;
                  case (s.phase)
                     KIND_INCOUNT: begin
                        r.parse_error   = cnt_err;
                        n.entries_left  = cnt_entries;
                        n.entry_counter = 16'd0;
                        n.phase = (cnt_entries != 16'd0) ? KIND_PREVHASH : KIND_OUTCOUNT;
                     end
                     KIND_OUTCOUNT: begin
                        r.parse_error   = cnt_err;
                        n.entries_left  = cnt_entries;
                        n.entry_counter = 16'd0;
                        n.phase = (cnt_entries != 16'd0) ? KIND_AMOUNT : KIND_LOCKTIME;
                     end
                     KIND_INSCRLEN: begin
                        r.parse_error       = len_err;
                        n.script_bytes_left = len_value;
                        n.script_offset     = 32'd0;
                        n.phase = (len_value != 32'd0) ? KIND_INSCRIPT : KIND_SEQUENCE;
                     end
                     default: begin
                        r.parse_error       = len_err;
                        n.script_bytes_left = len_value;
                        n.script_offset     = 32'd0;
                        if (len_value != 32'd0) begin
                           n.phase = KIND_OUTSCRIPT;
                        end else begin
                           n.entries_left  = entries_dec;
                           n.entry_counter = s.entry_counter + 16'd1;
                           n.phase = (entries_dec != 16'd0) ? KIND_AMOUNT : KIND_LOCKTIME;
                        end
                     end
                  endcase
               end
            end
            KIND_PREVHASH: begin
               r.entry_number   = s.entry_counter;
               r.byte_offset    = 32'(HASH_BYTES - 1) - {26'd0, fp};
               n.field_position = fp + 6'd1;
               if (fp >= 6'(HASH_BYTES - 1)) begin
                  r.field_last        = 1'b1;
                  n.phase             = KIND_PREVIDX;
                  n.field_position    = 6'd0;
                  n.value_accumulator = 64'd0;
                  n.varint_bytes_left = 4'd0;
               end
            end
            KIND_INSCRIPT, KIND_OUTSCRIPT: begin
               r.entry_number      = s.entry_counter;
               r.byte_offset       = s.script_offset;
               n.script_offset     = s.script_offset + 32'd1;
               n.script_bytes_left = s.script_bytes_left - 32'd1;
               if (s.script_bytes_left == 32'd1) begin
                  r.field_last        = 1'b1;
                  n.field_position    = 6'd0;
                  n.value_accumulator = 64'd0;
                  n.varint_bytes_left = 4'd0;
                  if (s.phase == KIND_INSCRIPT) begin
                     n.phase = KIND_SEQUENCE;
                  end else begin
                     n.entries_left  = entries_dec;
                     n.entry_counter = s.entry_counter + 16'd1;
                     n.phase = (entries_dec != 16'd0) ? KIND_AMOUNT : KIND_LOCKTIME;
                  end
               end
            end
            default: begin
               r.field_kind  = KIND_STRAY;
               r.parse_error = 1'b1;
            end
         endcase
      end

      state_nxt = n;
      result    = r;
   end

endmodule

@@ rtl/transaction_stream_parser.sv @@
// ---------------------------------------------------------------------------
// Transaction stream parser
// Tags each byte of a serialized legacy transaction with field, entry and
// offset, reports finished field values and the total of output amounts.
// ---------------------------------------------------------------------------
// Usage: raw transaction bytes enter on req_stream, one byte per item, with
// first_byte high on the first version byte of a new transaction. Each input
// item produces exactly one result item on rsp_stream, in order.
// An accepted item sits in the input register, is then parsed against the
// field state and lands in the result register, where it is offered on
// rsp_stream. Throughput is one item per cycle while the receiver takes
// results; the parse state is a single set of registers updated once per
// item, so a byte may follow in the next cycle.
// When the receiver stalls, the result register holds its item, the input
// register takes one more item, and then req_stream.ready drops until the
// result is taken.
// Reset (synchronous, active high) empties both registers and returns the
// parser to the start of the version field; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module transaction_stream_parser (
   input  logic     clock,
   input  logic     reset,
   tsp_req_if.sink   req_stream,
   tsp_rsp_if.source rsp_stream
);
   import tsp_pkg::*;

   // Input register: the byte waiting to be parsed.
   logic       in_vld_ff;
   logic       in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;

   // Result register: the tagged byte offered to the receiver.
   logic            out_vld_ff;
   logic            out_vld_in;
   step_result_type out_res_ff;

   // Field parse state, advanced once per parsed byte.
   parse_state_type state_ff;
   parse_state_type state_in;

   parse_state_type step_state;
   step_result_type step_result;

   logic req_take;
   logic advance;

   // Phase groups and occupancy used by the checks at the end.
   logic locktime_phase;
   logic entry_phase;
   logic script_phase;
   logic both_full;

   tsp_field_step u_step (
      .state_cur  (state_ff),
      .byte_value (in_byte_ff),
      .first_byte (in_first_ff),
      .state_nxt  (step_state),
      .result     (step_result)
   );

   // A byte moves on when the result register is empty or is being emptied.
   assign advance          = in_vld_ff && (!out_vld_ff || rsp_stream.ready);
   assign req_stream.ready = !in_vld_ff || !out_vld_ff || rsp_stream.ready;
   assign req_take         = req_stream.valid && req_stream.ready;

   always_comb begin
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end

      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_stream.ready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end

      state_in = advance ? step_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= STATE_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         state_ff   <= state_in;
      end
   end

   // Payload registers carry no reset; their valid flags guard them.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_stream.byte_value;
         in_first_ff <= req_stream.first_byte;
      end
      if (advance) begin
         out_res_ff <= step_result;
      end
   end

   assign rsp_stream.valid            = out_vld_ff;
   assign rsp_stream.field_kind       = out_res_ff.field_kind;
   assign rsp_stream.entry_number     = out_res_ff.entry_number;
   assign rsp_stream.byte_offset      = out_res_ff.byte_offset;
   assign rsp_stream.field_value      = out_res_ff.field_value;
   assign rsp_stream.value_valid      = out_res_ff.value_valid;
   assign rsp_stream.field_last       = out_res_ff.field_last;
   assign rsp_stream.transaction_done = out_res_ff.transaction_done;
   assign rsp_stream.output_total     = out_res_ff.output_total;
   assign rsp_stream.parse_error      = out_res_ff.parse_error;

   assign locktime_phase = state_ff.phase == KIND_LOCKTIME;
   assign script_phase   = state_ff.phase == KIND_INSCRIPT ||
                           state_ff.phase == KIND_OUTSCRIPT;
   assign entry_phase    = state_ff.phase == KIND_PREVHASH  ||
                           state_ff.phase == KIND_PREVIDX   ||
                           state_ff.phase == KIND_INSCRLEN  ||
                           state_ff.phase == KIND_SEQUENCE  ||
                           state_ff.phase == KIND_AMOUNT    ||
                           state_ff.phase == KIND_OUTSCRLEN ||
                           script_phase;
   assign both_full      = in_vld_ff && out_vld_ff;

   // The end flag is only ever raised by the locktime field.
   `ASSERT_IMPLIES(a_finished_in_locktime, clock, reset, state_ff.finished, locktime_phase)

   // Per-entry phases are only entered with at least one entry left.
   `ASSERT_IMPLIES(a_entry_phase_has_entries, clock, reset, entry_phase, state_ff.entries_left != 16'd0)

   // Script phases are only entered with a nonzero remaining length.
   `ASSERT_IMPLIES(a_script_phase_has_bytes, clock, reset, script_phase, |state_ff.script_bytes_left)

   // A stalled result with a byte already waiting blocks new input, and the
   // waiting byte is still there at the next edge.
   `ASSERT_NEXT(a_stall_keeps_pending, clock, reset, both_full && !rsp_stream.ready, both_full)

endmodule

@@ tb/transaction_stream_parser_tb.sv @@
// ---------------------------------------------------------------------------
// Transaction stream parser testbench
// Feeds serialized legacy transactions byte by byte, well formed, cut short
// and plain noise, and checks every tagged result item against a parser
// model kept inside the bench, with random gaps on both channels.
// ---------------------------------------------------------------------------
module transaction_stream_parser_tb;

   import tsp_pkg::*;

   // The bench gives up when this many cycles pass with no item moving on
   // either channel. The longest legal quiet stretch is the long receiver
   // hold plus a long sender gap.
   localparam int unsigned WATCHDOG_CYCLES = 2000;
   localparam int unsigned RANDOM_ITEMS    = 100;
   localparam int unsigned HOLD_CYCLES     = 64;
   localparam logic [7:0]  VARINT_PREFIX_8 = 8'hFF;

   // How a varint is written into the stream. FORM_ANY picks the minimal
   // form most of the time and otherwise any form from the minimal one up.
   typedef enum int {
      FORM_BYTE,
      FORM_WORD16,
      FORM_WORD32,
      FORM_WORD64,
      FORM_ANY
   } varint_form_type;

   logic clock;
   logic reset;

   tsp_req_if req_stream ();
   tsp_rsp_if rsp_stream ();

   transaction_stream_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_stream),
      .rsp_stream (rsp_stream)
   );

   // Tags that the parser must produce, oldest first.
   step_result_type expected_tags[$];
   int unsigned     mismatches;
   int unsigned     bytes_sent;

   // Bytes of the transaction being built before it is sent.
   logic [7:0] tx_bytes[$];

   // Idling controls. The sender reads its own flag; the receiver flag and
   // the hold request are written with nonblocking assignments so that the
   // receiver process always sees a settled value.
   bit          sender_pauses;
   bit          receiver_pauses;
   int unsigned hold_requests;
   int unsigned holds_served;

   // Parser model state. It mirrors what the block keeps between bytes.
   field_kind_type cur_field;
   logic [5:0]     pos;
   logic [63:0]    acc;
   logic [3:0]     vbytes;
   logic [15:0]    entries_remaining;
   logic [15:0]    entry_idx;
   logic [31:0]    script_remaining;
   logic [31:0]    script_pos;
   logic [63:0]    amount_total;
   logic           tx_complete;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Parser model
   // -------------------------------------------------------------------------

   // Moves to a new field and clears the per-field state.
   function automatic void enter(input field_kind_type kind);
      cur_field = kind;
      pos       = '0;
      acc       = '0;
      vbytes    = '0;
   endfunction

   function automatic void restart_parser();
      enter(KIND_VERSION);
      entries_remaining = '0;
      entry_idx         = '0;
      script_remaining  = '0;
      script_pos        = '0;
      amount_total      = '0;
      tx_complete       = 1'b0;
   endfunction

   // One byte of a fixed-size little-endian field; true on its last byte.
   function automatic bit fixed_byte(input logic [7:0] b, input int unsigned n,
                                     output logic [31:0] off);
      off = 32'(pos);
      acc = acc | (64'(b) << (8 * (pos & 6'd7)));
      pos = pos + 6'd1;
      return (pos >= n);
   endfunction

   // One byte of a varint; true when the value is complete. The prefix byte
   // is offset 0 and the payload bytes follow at offsets 1 and up.
   function automatic bit varint_byte(input logic [7:0] b, output logic [31:0] off,
                                      output logic [63:0] val);
      off = 32'(pos);
      val = '0;
      if (pos == 6'd0) begin
         if (b < VARINT_PREFIX_2) begin
            val = 64'(b);
            return 1'b1;
         end
         vbytes = (b == VARINT_PREFIX_2) ? 4'd2 : (b == VARINT_PREFIX_4) ? 4'd4 : 4'd8;
         acc    = '0;
         pos    = 6'd1;
         return 1'b0;
      end
      acc    = acc | (64'(b) << (8 * ((pos - 6'd1) & 6'd7)));
      pos    = pos + 6'd1;
      vbytes = vbytes - 4'd1;
      if (vbytes == 4'd0) begin
         val = acc;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // A count above capacity is an error; parsing goes on at full capacity.
   function automatic bit begin_entries(input logic [63:0] count,
                                        input field_kind_type first_kind,
                                        input field_kind_type after_kind);
      bit too_many;
      too_many          = (count > MAX_ENTRIES);
      entries_remaining = too_many ? 16'(MAX_ENTRIES) : count[15:0];
      entry_idx         = '0;
      enter((entries_remaining != 16'd0) ? first_kind : after_kind);
      return too_many;
   endfunction

   // A script length beyond 32 bits is an error and is clipped.
   function automatic bit begin_script(input logic [63:0] len);
      bit too_long;
      too_long         = (len > 64'(MAX_SCRIPT_LEN));
      script_remaining = too_long ? MAX_SCRIPT_LEN : len[31:0];
      script_pos       = '0;
      return too_long;
   endfunction

   function automatic void advance_entry(input field_kind_type first_kind,
                                         input field_kind_type after_kind);
      entries_remaining = entries_remaining - 16'd1;
      entry_idx         = entry_idx + 16'd1;
      enter((entries_remaining != 16'd0) ? first_kind : after_kind);
   endfunction

   // Works out the tag of one accepted byte and advances the model.
   function automatic step_result_type tag_byte(input logic [7:0] b, input logic restart);
      step_result_type res;
      logic [63:0]     val;
      logic [31:0]     off;
      res            = '0;
      res.field_kind = KIND_STRAY;
      val            = '0;
      off            = '0;
      if (restart)
         restart_parser();
      if (tx_complete) begin
         // Anything after the locktime without a restart is stray.
         res.parse_error = 1'b1;
      end else begin
         res.field_kind = cur_field;
         case (cur_field)
            KIND_VERSION: begin
               if (fixed_byte(b, WORD_BYTES, off)) begin
                  val = acc;
                  res.value_valid = 1'b1;
                  res.field_last  = 1'b1;
                  enter(KIND_INCOUNT);
               end
            end
            KIND_INCOUNT: begin
               if (varint_byte(b, off, val)) begin
                  res.value_valid = 1'b1;
                  res.field_last  = 1'b1;
                  res.parse_error = begin_entries(val, KIND_PREVHASH, KIND_OUTCOUNT);
               end
            end
            KIND_PREVHASH: begin
               // Hash positions are reported from the top byte down.
               res.entry_number = entry_idx;
               off = HASH_BYTES - 1 - 32'(pos);
               pos = pos + 6'd1;
               if (pos >= HASH_BYTES) begin
                  res.field_last = 1'b1;
                  enter(KIND_PREVIDX);
               end
            end
            KIND_PREVIDX: begin
               res.entry_number = entry_idx;
               if (fixed_byte(b, WORD_BYTES, off)) begin
                  val = acc;
                  res.value_valid = 1'b1;
                  res.field_last  = 1'b1;
                  enter(KIND_INSCRLEN);
               end
            end
            KIND_INSCRLEN: begin
               res.entry_number = entry_idx;
               if (varint_byte(b, off, val)) begin
                  res.value_valid = 1'b1;
                  res.field_last  = 1'b1;
                  res.parse_error = begin_script(val);
                  enter((script_remaining != 32'd0) ? KIND_INSCRIPT : KIND_SEQUENCE);
               end
            end
            KIND_INSCRIPT, KIND_OUTSCRIPT: begin
               res.entry_number = entry_idx;
               off              = script_pos;
               script_pos       = script_pos + 32'd1;
               script_remaining = script_remaining - 32'd1;
               if (script_remaining == 32'd0) begin
                  res.field_last = 1'b1;
                  if (cur_field == KIND_INSCRIPT)
                     enter(KIND_SEQUENCE);
                  else
                     advance_entry(KIND_AMOUNT, KIND_LOCKTIME);
               end
            end
            KIND_SEQUENCE: begin
               res.entry_number = entry_idx;
               if (fixed_byte(b, WORD_BYTES, off)) begin
                  val = acc;
                  res.value_valid = 1'b1;
                  res.field_last  = 1'b1;
                  advance_entry(KIND_PREVHASH, KIND_OUTCOUNT);
               end
            end
            KIND_OUTCOUNT: begin
               if (varint_byte(b, off, val)) begin
                  res.value_valid = 1'b1;
                  res.field_last  = 1'b1;
                  res.parse_error = begin_entries(val, KIND_AMOUNT, KIND_LOCKTIME);
               end
            end
            KIND_AMOUNT: begin
               res.entry_number = entry_idx;
               if (fixed_byte(b, AMOUNT_BYTES, off)) begin
                  val = acc;
                  res.value_valid = 1'b1;
                  res.field_last  = 1'b1;
                  amount_total    = amount_total + acc;
                  enter(KIND_OUTSCRLEN);
               end
            end
            KIND_OUTSCRLEN: begin
               res.entry_number = entry_idx;
               if (varint_byte(b, off, val)) begin
                  res.value_valid = 1'b1;
                  res.field_last  = 1'b1;
                  res.parse_error = begin_script(val);
                  if (script_remaining != 32'd0)
                     enter(KIND_OUTSCRIPT);
                  else
                     advance_entry(KIND_AMOUNT, KIND_LOCKTIME);
               end
            end
            KIND_LOCKTIME: begin
               if (fixed_byte(b, WORD_BYTES, off)) begin
                  val = acc;
                  res.value_valid      = 1'b1;
                  res.field_last       = 1'b1;
                  res.transaction_done = 1'b1;
                  res.output_total     = amount_total;
                  tx_complete          = 1'b1;
               end
            end
            default: ;
         endcase
      end
      res.byte_offset = off;
      res.field_value = res.value_valid ? val : 64'd0;
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Channel handling
   // -------------------------------------------------------------------------

   // Gap lengths: mostly short, now and then long.
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Offers one byte and returns on the edge at which it is taken. All
   // handshake signals change only at rising edges, so sampling ready at the
   // falling edge before shows what the next rising edge will see.
   task automatic send_byte(input logic [7:0] value, input logic restart);
      int unsigned idle;
      logic        taken;
      idle = 0;
      if (sender_pauses && $urandom_range(0, 99) < 30)
         idle = gap_len();
      if (idle != 0) begin
         req_stream.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_stream.valid      <= 1'b1;
      req_stream.byte_value <= value;
      req_stream.first_byte <= restart;
      do begin
         @(negedge clock);
         taken = req_stream.ready;
         @(posedge clock);
      end while (!taken);
      bytes_sent++;
   endtask

   // Sends the first keep bytes of the built transaction; the first byte
   // carries the restart mark if asked.
   task automatic send_bytes(input logic restart, input int unsigned keep);
      int unsigned count;
      count = (keep < tx_bytes.size()) ? keep : tx_bytes.size();
      for (int unsigned i = 0; i < count; i++)
         send_byte(tx_bytes[i], (i == 0) ? restart : 1'b0);
   endtask

   // Bytes with no restart mark; after a finished transaction they are stray.
   task automatic send_stray(input int unsigned n);
      repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   // The receiver stalls at random while its flag is set, and takes one long
   // hold whenever the test asks for it.
   initial begin : receiver
      int unsigned stall_left;
      stall_left       = 0;
      holds_served     = 0;
      rsp_stream.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            stall_left--;
            rsp_stream.ready <= 1'b0;
         end else if (hold_requests != holds_served) begin
            holds_served++;
            stall_left = HOLD_CYCLES - 1;
            rsp_stream.ready <= 1'b0;
         end else if (receiver_pauses && $urandom_range(0, 99) < 25) begin
            stall_left = gap_len() - 1;
            rsp_stream.ready <= 1'b0;
         end else begin
            rsp_stream.ready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Each result item is checked against the oldest expectation, and each
   // byte that the parser takes adds one expectation. Checking comes first,
   // which is safe since a result is registered only after its byte is taken.
   always @(negedge clock) begin : check_results
      step_result_type want;
      if (!reset) begin
         if (rsp_stream.valid && rsp_stream.ready) begin
            if (expected_tags.size() == 0) begin
               $display("%0t: result item with nothing expected, kind %0d offset %0h",
                        $time, rsp_stream.field_kind, rsp_stream.byte_offset);
               mismatches++;
            end else begin
               want = expected_tags.pop_front();
               check_field("field_kind", want.field_kind, rsp_stream.field_kind);
               check_field("entry_number", want.entry_number, rsp_stream.entry_number);
               check_field("byte_offset", want.byte_offset, rsp_stream.byte_offset);
               check_field("field_value", want.field_value, rsp_stream.field_value);
               check_field("value_valid", want.value_valid, rsp_stream.value_valid);
               check_field("field_last", want.field_last, rsp_stream.field_last);
               check_field("transaction_done", want.transaction_done,
                           rsp_stream.transaction_done);
               check_field("output_total", want.output_total, rsp_stream.output_total);
               check_field("parse_error", want.parse_error, rsp_stream.parse_error);
            end
         end
         if (req_stream.valid && req_stream.ready)
            expected_tags.push_back(tag_byte(req_stream.byte_value, req_stream.first_byte));
      end
   end

   // Ends the run if nothing moves on either channel for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(negedge clock);
         if (reset || (req_stream.valid && req_stream.ready) ||
             (rsp_stream.valid && rsp_stream.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= WATCHDOG_CYCLES) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet);
            $display("transaction_stream_parser_tb: FAIL");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Transaction building
   // -------------------------------------------------------------------------

   function automatic void push_word(input int unsigned n, input logic [63:0] v);
      for (int unsigned i = 0; i < n; i++)
         tx_bytes.push_back(v[8*i +: 8]);
   endfunction

   function automatic void push_random(input int unsigned n);
      repeat (n) tx_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void push_varint(input logic [63:0] v, input varint_form_type form);
      varint_form_type shortest;
      if (form == FORM_ANY) begin
         shortest = (v < 64'(VARINT_PREFIX_2)) ? FORM_BYTE :
                    (v <= 64'hFFFF)            ? FORM_WORD16 :
                    (v <= 64'hFFFF_FFFF)       ? FORM_WORD32 : FORM_WORD64;
         form = shortest;
         if ($urandom_range(0, 3) == 0)
            form = varint_form_type'($urandom_range(int'(shortest), int'(FORM_WORD64)));
      end
      case (form)
         FORM_BYTE:   tx_bytes.push_back(v[7:0]);
         FORM_WORD16: begin
            tx_bytes.push_back(VARINT_PREFIX_2);
            push_word(2, v);
         end
         FORM_WORD32: begin
            tx_bytes.push_back(VARINT_PREFIX_4);
            push_word(4, v);
         end
         default: begin
            tx_bytes.push_back(VARINT_PREFIX_8);
            push_word(8, v);
         end
      endcase
   endfunction

   // Builds a complete, well-formed transaction with random content.
   function automatic void build_transaction(input int unsigned n_in, input int unsigned n_out,
                                             input int unsigned max_script);
      int unsigned len;
      logic [63:0] amount;
      tx_bytes.delete();
      push_word(4, 64'($urandom));
      push_varint(64'(n_in), FORM_ANY);
      for (int unsigned i = 0; i < n_in; i++) begin
         push_random(HASH_BYTES);
         push_word(4, 64'($urandom));
         len = $urandom_range(0, max_script);
         push_varint(64'(len), FORM_ANY);
         push_random(len);
         push_word(4, 64'($urandom));
      end
      push_varint(64'(n_out), FORM_ANY);
      for (int unsigned i = 0; i < n_out; i++) begin
         // Amounts are mostly random, sometimes at the extremes.
         case ($urandom_range(0, 7))
            0:       amount = '1;
            1:       amount = '0;
            default: amount = {$urandom, $urandom};
         endcase
         push_word(AMOUNT_BYTES, amount);
         len = $urandom_range(0, max_script);
         push_varint(64'(len), FORM_ANY);
         push_random(len);
      end
      push_word(4, 64'($urandom));
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // The first transaction after reset carries no restart mark; it must still
   // be parsed from the version field. Bytes after its end are stray.
   task automatic test_first_after_reset();
      build_transaction(1, 1, 4);
      send_bytes(1'b0, tx_bytes.size());
      send_stray(2);
   endtask

   // Zero inputs, zero outputs and zero script lengths skip their parts.
   task automatic test_empty_sections();
      build_transaction(0, 0, 0);
      send_bytes(1'b1, tx_bytes.size());
      build_transaction(1, 1, 0);
      send_bytes(1'b1, tx_bytes.size());
      send_stray(1);
   endtask

   // Every varint prefix, minimal and non-minimal encodings, and the largest
   // length that still fits in one byte.
   task automatic test_varint_forms();
      tx_bytes.delete();
      push_word(4, 64'hFFFF_FFFF);
      push_varint(1, FORM_WORD64);
      push_random(HASH_BYTES);
      push_word(4, 64'h0);
      push_varint(252, FORM_BYTE);
      push_random(252);
      push_word(4, 64'hFFFF_FFFF);
      push_varint(2, FORM_WORD32);
      push_word(AMOUNT_BYTES, 64'h0123_4567_89AB_CDEF);
      push_varint(0, FORM_WORD64);
      push_word(AMOUNT_BYTES, 64'h8000_0000_0000_0001);
      push_varint(3, FORM_WORD16);
      push_random(3);
      push_word(4, 64'h0);
      send_bytes(1'b1, tx_bytes.size());
   endtask

   // The output total wraps around modulo 2^64.
   task automatic test_amount_wraparound();
      tx_bytes.delete();
      push_word(4, 64'd1);
      push_varint(0, FORM_BYTE);
      push_varint(4, FORM_BYTE);
      push_word(AMOUNT_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
      push_varint(0, FORM_BYTE);
      push_word(AMOUNT_BYTES, 64'h8000_0000_0000_0000);
      push_varint(1, FORM_BYTE);
      push_random(1);
      push_word(AMOUNT_BYTES, 64'd2);
      push_varint(0, FORM_BYTE);
      push_word(AMOUNT_BYTES, 64'd0);
      push_varint(0, FORM_BYTE);
      push_word(4, 64'hFFFF_FFFF);
      send_bytes(1'b1, tx_bytes.size());
      send_stray(1);
   endtask

   // Counts above capacity raise the error and go on at full capacity; the
   // full capacity itself is legal. Each case is cut short by a restart.
   task automatic test_count_overflow();
      tx_bytes.delete();
      push_random(4);
      push_varint(64'h1_0000, FORM_WORD32);
      push_random(16);
      send_bytes(1'b1, tx_bytes.size());

      tx_bytes.delete();
      push_random(4);
      push_varint(64'hFFFF, FORM_WORD16);
      push_random(45);
      send_bytes(1'b1, tx_bytes.size());

      tx_bytes.delete();
      push_random(4);
      push_varint(0, FORM_BYTE);
      push_varint('1, FORM_WORD64);
      push_random(12);
      send_bytes(1'b1, tx_bytes.size());
   endtask

   // Script lengths beyond 32 bits raise the error and are clipped; the
   // largest 32-bit length is legal.
   task automatic test_script_overflow();
      tx_bytes.delete();
      push_random(4);
      push_varint(1, FORM_BYTE);
      push_random(HASH_BYTES + 4);
      push_varint(64'h1_0000_0000, FORM_WORD64);
      push_random(8);
      send_bytes(1'b1, tx_bytes.size());

      tx_bytes.delete();
      push_random(4);
      push_varint(1, FORM_BYTE);
      push_random(HASH_BYTES + 4);
      push_varint(64'hFFFF_FFFF, FORM_WORD32);
      push_random(6);
      send_bytes(1'b1, tx_bytes.size());

      tx_bytes.delete();
      push_random(4);
      push_varint(0, FORM_BYTE);
      push_varint(1, FORM_BYTE);
      push_random(AMOUNT_BYTES);
      push_varint('1, FORM_WORD64);
      push_random(6);
      send_bytes(1'b1, tx_bytes.size());
   endtask

   // A restart in the middle of a transaction drops everything parsed so far.
   task automatic test_restart_midstream();
      build_transaction(2, 2, 5);
      send_bytes(1'b1, 30);
      build_transaction(1, 1, 3);
      send_bytes(1'b1, tx_bytes.size());
      send_stray(1);
   endtask

   // The receiver holds off for a long stretch while bytes keep coming, so
   // the block fills up and has to stall its input.
   task automatic test_receiver_hold();
      sender_pauses = 1'b0;
      receiver_pauses <= 1'b0;
      hold_requests <= hold_requests + 1;
      build_transaction(1, 2, 8);
      send_bytes(1'b1, tx_bytes.size());
   endtask

   // Mostly well-formed transactions with random content and random idling,
   // with some cut short, some followed by stray bytes and some plain noise.
   task automatic test_random_transactions();
      int unsigned stop_at;
      int unsigned r;
      stop_at = bytes_sent + RANDOM_ITEMS;
      while (bytes_sent < stop_at) begin
         sender_pauses = ($urandom_range(0, 3) != 0);
         receiver_pauses <= ($urandom_range(0, 3) != 0);
         r = $urandom_range(0, 99);
         if (r < 75) begin
            build_transaction($urandom_range(0, 2), $urandom_range(0, 3),
                              ($urandom_range(0, 5) == 0) ? 40 : 6);
            send_bytes(1'b1, tx_bytes.size());
            if ($urandom_range(0, 4) == 0)
               send_stray($urandom_range(1, 3));
         end else if (r < 88) begin
            build_transaction($urandom_range(1, 2), $urandom_range(1, 2), 6);
            send_bytes(1'b1, $urandom_range(1, tx_bytes.size() - 1));
         end else begin
            tx_bytes.delete();
            push_random($urandom_range(4, 24));
            send_bytes(logic'($urandom_range(0, 3) != 0), tx_bytes.size());
         end
      end
   endtask

   initial begin
      mismatches      = 0;
      bytes_sent      = 0;
      hold_requests   = 0;
      sender_pauses   = 1'b1;
      receiver_pauses = 1'b1;
      restart_parser();

      reset                 = 1'b1;
      req_stream.valid      = 1'b0;
      req_stream.byte_value = 8'd0;
      req_stream.first_byte = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_first_after_reset();
      test_empty_sections();
      test_varint_forms();
      test_amount_wraparound();
      test_count_overflow();
      test_script_overflow();
      test_restart_midstream();
      test_receiver_hold();
      test_random_transactions();

      // Let the last results drain; the watchdog bounds this wait.
      req_stream.valid <= 1'b0;
      receiver_pauses  <= 1'b0;
      while (expected_tags.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatches == 0)
         $display("transaction_stream_parser_tb: PASS");
      else
         $display("transaction_stream_parser_tb: FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tsp_pkg.sv
rtl/tsp_stream_if.sv
rtl/tsp_field_step.sv
rtl/transaction_stream_parser.sv
tb/transaction_stream_parser_tb.sv
